[rtl/bgk_pkg.sv]
// D2Q9 BGK collision: shared widths, word types, direction tables and saturation.
// Used by bgk_div, bgk_lane and d2q9_bgk_cell_collision.
`default_nettype none

package bgk_pkg;

  localparam int FRAC_BITS = 16;
  localparam int W         = 20;
  localparam int RATE_W    = 18;
  localparam int CFG_W     = W;
  localparam int NDIR      = 9;
  localparam int DIR_W     = 4;

  localparam int ONE     = 2 ** FRAC_BITS;
  localparam int SAT_MAX = 2 ** (W - 1) - 1;
  localparam int SAT_MIN = -(2 ** (W - 1));

  localparam int SUM_W   = W + 4;
  localparam int NUM_W   = SUM_W + FRAC_BITS;
  localparam int DEN_W   = W - 1;
  localparam int CMP_A   = DEN_W + W + 1;
  localparam int CMP_W   = (NUM_W > CMP_A) ? NUM_W : CMP_A;
  localparam int DIV_LAT = W + 1;

  localparam int SQU_W = 2 * W - 1;
  localparam int USQ_W = 2 * W + 2;
  localparam int CU_W  = W + 2;
  localparam int SQ_W  = 2 * W + 1;

  localparam int POLY_A = 2 * W + 8 - FRAC_BITS;
  localparam int POLY_B = FRAC_BITS + 3;
  localparam int POLY_W = (POLY_A > POLY_B) ? POLY_A : POLY_B;
  localparam int PROD_W = W + POLY_W + 4;

  localparam int T_W     = W + 4;
  localparam int T_MAX   = 9 * (2 ** W);
  localparam int RECIP_K = T_W + 4;
  localparam int RCP_W   = RECIP_K - 3;
  localparam int RECIP   = (2 ** RECIP_K + 8) / 9;
  localparam int P9_W    = T_W + RCP_W;

  localparam int M_W      = RATE_W + 1 + W + 1;
  localparam int SAT_IN_W = 48;
  localparam int LANE_LAT = 9;

  typedef logic signed [W-1:0] word_t;

  localparam word_t INLET_RHO = (ONE > SAT_MAX) ? W'(SAT_MAX) : W'(ONE);

  typedef enum logic [0:0] {
    REG_RELAX_RATE     = 1'b0,
    REG_INLET_VELOCITY = 1'b1
  } reg_index_t;

  typedef struct packed {
    word_t in_rest;
    word_t in_east;
    word_t in_north;
    word_t in_west;
    word_t in_south;
    word_t in_northeast;
    word_t in_northwest;
    word_t in_southwest;
    word_t in_southeast;
    logic  is_obstacle;
    logic  is_inlet;
  } in_word_t;

  typedef struct packed {
    word_t out_rest;
    word_t out_east;
    word_t out_north;
    word_t out_west;
    word_t out_south;
    word_t out_northeast;
    word_t out_northwest;
    word_t out_southwest;
    word_t out_southeast;
    word_t density;
    word_t velocity_x;
    word_t velocity_y;
  } out_word_t;

  typedef struct packed {
    word_t              rho;
    word_t              ux;
    word_t              uy;
    logic [USQ_W-1:0]   usq3;
  } lane_in_t;

  function automatic logic signed [1:0] dir_x(input logic [DIR_W-1:0] d);
    case (d)
      4'd1, 4'd5, 4'd8: dir_x = 2'sd1;
      4'd3, 4'd6, 4'd7: dir_x = -2'sd1;
      default:          dir_x = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_y(input logic [DIR_W-1:0] d);
    case (d)
      4'd2, 4'd5, 4'd6: dir_y = 2'sd1;
      4'd4, 4'd7, 4'd8: dir_y = -2'sd1;
      default:          dir_y = 2'sd0;
    endcase
  endfunction

  function automatic logic [2:0] weight_shift(input logic [DIR_W-1:0] d);
    case (d)
      4'd0:                   weight_shift = 3'd4;
      4'd1, 4'd2, 4'd3, 4'd4: weight_shift = 3'd2;
      default:                weight_shift = 3'd0;
    endcase
  endfunction

  function automatic logic [DIR_W-1:0] mirror(input logic [DIR_W-1:0] d);
    case (d)
      4'd1:    mirror = 4'd3;
      4'd2:    mirror = 4'd4;
      4'd3:    mirror = 4'd1;
      4'd4:    mirror = 4'd2;
      4'd5:    mirror = 4'd7;
      4'd6:    mirror = 4'd8;
      4'd7:    mirror = 4'd5;
      4'd8:    mirror = 4'd6;
      default: mirror = 4'd0;
    endcase
  endfunction

  function automatic word_t sat_word(input logic signed [SAT_IN_W-1:0] v);
    if (v > SAT_IN_W'(SAT_MAX)) sat_word = W'(SAT_MAX);
    else if (v < SAT_IN_W'(SAT_MIN)) sat_word = W'(SAT_MIN);
    else sat_word = v[W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/d2q9_bgk_cell_collision.sv]
// D2Q9 BGK cell collision top: moments, velocity dividers, nine direction lanes, bounce-back merge.
// Depends on bgk_pkg, bgk_div and bgk_lane.
//
// Usage:
//   Input channel in_valid/in_stall/in_word carries one lattice cell (nine distributions,
//   obstacle and inlet flags). Output channel out_valid/out_stall/out_word carries the nine
//   post-collision distributions with the density and velocity that were used.
//   One cell is accepted every cycle unless the pipeline holds. Register stages: moment sum 1,
//   velocity divider 21, inlet select, squares and velocity term 3, direction lanes 9, merge register 1.
//   The velocity divider resolves one quotient bit per stage, which sets the depth.
//   The whole pipeline advances together; it holds only while a word sits in the output
//   register and out_stall is high, and in_stall is raised in exactly those cycles.
//   Configuration writes (cfg_write, cfg_index, cfg_data) set relax_rate and
//   inlet_velocity; write them only while the pipeline is empty.
//   Reset (rst, synchronous) empties the pipeline and restores both registers.
`default_nettype none

module d2q9_bgk_cell_collision (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire bgk_pkg::reg_index_t           cfg_index,
  input  wire logic [bgk_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire bgk_pkg::in_word_t             in_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output bgk_pkg::out_word_t                 out_word
);
  import bgk_pkg::*;

  localparam int VLD_N = 1 + DIV_LAT + 3 + LANE_LAT;

  typedef struct packed {
    logic  obstacle;
    word_t rho;
    word_t ux;
    word_t uy;
  } side_t;

  logic [RATE_W-1:0] relax_rate;
  word_t             inlet_velocity;
  logic              adv;
  logic [VLD_N-1:0]  vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_rate     <= RATE_W'(126031);
      inlet_velocity <= W'(2621);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RELAX_RATE:     relax_rate     <= cfg_data[RATE_W-1:0];
        REG_INLET_VELOCITY: inlet_velocity <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[VLD_N-2:0], in_valid};
      out_valid <= vld[VLD_N-1];
    end
  end

  logic signed [SUM_W-1:0] sum, mx, my;
  logic signed [SUM_W-1:0] mom_mx, mom_my;
  word_t                   mom_rho;
  in_word_t                mom_w;

  always_comb begin
    sum = SUM_W'(in_word.in_rest) + SUM_W'(in_word.in_east) + SUM_W'(in_word.in_north)
        + SUM_W'(in_word.in_west) + SUM_W'(in_word.in_south) + SUM_W'(in_word.in_northeast)
        + SUM_W'(in_word.in_northwest) + SUM_W'(in_word.in_southwest)
        + SUM_W'(in_word.in_southeast);
    mx  = SUM_W'(in_word.in_east) + SUM_W'(in_word.in_northeast)
        + SUM_W'(in_word.in_southeast) - SUM_W'(in_word.in_west)
        - SUM_W'(in_word.in_northwest) - SUM_W'(in_word.in_southwest);
    my  = SUM_W'(in_word.in_north) + SUM_W'(in_word.in_northeast)
        + SUM_W'(in_word.in_northwest) - SUM_W'(in_word.in_south)
        - SUM_W'(in_word.in_southwest) - SUM_W'(in_word.in_southeast);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mom_rho <= sat_word(SAT_IN_W'(sum));
      mom_mx  <= mx;
      mom_my  <= my;
      mom_w   <= in_word;
    end
  end

  word_t ux_q, uy_q;

  bgk_div u_div_x (.clk(clk), .adv(adv), .num(mom_mx), .den(mom_rho), .quo(ux_q));
  bgk_div u_div_y (.clk(clk), .adv(adv), .num(mom_my), .den(mom_rho), .quo(uy_q));

  in_word_t dly_w   [DIV_LAT];
  word_t    dly_rho [DIV_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      dly_w[0]   <= mom_w;
      dly_rho[0] <= mom_rho;
      for (int k = 1; k < DIV_LAT; k++) begin
        dly_w[k]   <= dly_w[k-1];
        dly_rho[k] <= dly_rho[k-1];
      end
    end
  end

  word_t              p1_rho, p1_ux, p1_uy, p2_rho, p2_ux, p2_uy;
  in_word_t           p1_w, p2_w, p3_w;
  logic [SQU_W-1:0]   p2_uxx, p2_uyy;
  logic signed [2*W-1:0] sqx, sqy;
  logic [USQ_W-1:0]   usum;
  lane_in_t           p3_lin;

  always_comb begin
    sqx  = p1_ux * p1_ux;
    sqy  = p1_uy * p1_uy;
    usum = USQ_W'(p2_uxx) + USQ_W'(p2_uyy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_w   <= dly_w[DIV_LAT-1];
      p1_rho <= dly_w[DIV_LAT-1].is_inlet ? INLET_RHO : dly_rho[DIV_LAT-1];
      p1_ux  <= dly_w[DIV_LAT-1].is_inlet ? inlet_velocity : ux_q;
      p1_uy  <= dly_w[DIV_LAT-1].is_inlet ? '0 : uy_q;

      p2_w   <= p1_w;
      p2_rho <= p1_rho;
      p2_ux  <= p1_ux;
      p2_uy  <= p1_uy;
      p2_uxx <= sqx[SQU_W-1:0];
      p2_uyy <= sqy[SQU_W-1:0];

      p3_w        <= p2_w;
      p3_lin.rho  <= p2_rho;
      p3_lin.ux   <= p2_ux;
      p3_lin.uy   <= p2_uy;
      p3_lin.usq3 <= (usum + (usum << 1)) >> (FRAC_BITS + 1);
    end
  end

  word_t fin  [NDIR];
  word_t post [NDIR];

  assign fin[0] = p3_w.in_rest;
  assign fin[1] = p3_w.in_east;
  assign fin[2] = p3_w.in_north;
  assign fin[3] = p3_w.in_west;
  assign fin[4] = p3_w.in_south;
  assign fin[5] = p3_w.in_northeast;
  assign fin[6] = p3_w.in_northwest;
  assign fin[7] = p3_w.in_southwest;
  assign fin[8] = p3_w.in_southeast;

  for (genvar q = 0; q < NDIR; q++) begin : g_lane
    bgk_lane u_lane (
      .clk   (clk),
      .adv   (adv),
      .dir   (DIR_W'(q)),
      .lin   (p3_lin),
      .omega (relax_rate),
      .f     (fin[q]),
      .inlet (p3_w.is_inlet),
      .post  (post[q])
    );
  end

  side_t side [LANE_LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= '{obstacle: p3_w.is_obstacle, rho: p3_lin.rho, ux: p3_lin.ux, uy: p3_lin.uy};
      for (int k = 1; k < LANE_LAT; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  word_t sel [NDIR];

  always_comb begin
    for (int q = 0; q < NDIR; q++) begin
      sel[q] = side[LANE_LAT-1].obstacle ? post[mirror(DIR_W'(q))] : post[q];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word.out_rest      <= sel[0];
      out_word.out_east      <= sel[1];
      out_word.out_north     <= sel[2];
      out_word.out_west      <= sel[3];
      out_word.out_south     <= sel[4];
      out_word.out_northeast <= sel[5];
      out_word.out_northwest <= sel[6];
      out_word.out_southwest <= sel[7];
      out_word.out_southeast <= sel[8];
      out_word.density       <= side[LANE_LAT-1].rho;
      out_word.velocity_x    <= side[LANE_LAT-1].ux;
      out_word.velocity_y    <= side[LANE_LAT-1].uy;
    end
  end

  a_vel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.density <= 0) |->
      (out_word.velocity_x == '0) && (out_word.velocity_y == '0))
    else $error("nonzero velocity with nonpositive density");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld) && out_valid)
    else $error("pipeline moved while output blocked");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && (vld == '0))
    else $error("pipeline not empty after reset");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

[rtl/bgk_div.sv]
// Pipelined restoring divider: saturated signed momentum * ONE / density, one bit per stage.
// Depends on bgk_pkg.
`default_nettype none

module bgk_div (
  input  wire logic                          clk,
  input  wire logic                          adv,
  input  wire logic signed [bgk_pkg::SUM_W-1:0] num,
  input  wire bgk_pkg::word_t                den,
  output bgk_pkg::word_t                     quo
);
  import bgk_pkg::*;

  logic [CMP_W-1:0] rem [W+1];
  logic [W-1:0]     qb  [W+1];
  logic [DEN_W-1:0] dv  [W+1];
  logic             neg_s [W+1];
  logic             ovf_s [W+1];
  logic             pos_s [W+1];

  logic             neg0;
  logic [SUM_W-1:0] nmag;
  logic [CMP_W-1:0] nn;
  logic [CMP_W-1:0] dtop;

  always_comb begin
    neg0 = num[SUM_W-1];
    nmag = neg0 ? SUM_W'(-num) : SUM_W'(num);
    nn   = CMP_W'({nmag, {FRAC_BITS{1'b0}}});
    dtop = CMP_W'({den[DEN_W-1:0], {W{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0]   <= nn;
      qb[0]    <= '0;
      dv[0]    <= den[DEN_W-1:0];
      neg_s[0] <= neg0;
      ovf_s[0] <= nn >= dtop;
      pos_s[0] <= !den[W-1] && (den != '0);
    end
  end

  for (genvar k = 1; k <= W; k++) begin : g_step
    localparam int B = W - k;
    logic [CMP_W-1:0] sh;
    logic             ge;
    always_comb begin
      sh = CMP_W'(dv[k-1]) << B;
      ge = rem[k-1] >= sh;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]   <= ge ? rem[k-1] - sh : rem[k-1];
        qb[k]    <= qb[k-1] | (ge ? (W'(1) << B) : '0);
        dv[k]    <= dv[k-1];
        neg_s[k] <= neg_s[k-1];
        ovf_s[k] <= ovf_s[k-1];
        pos_s[k] <= pos_s[k-1];
      end
    end
  end

  logic [W:0] mag;

  always_comb begin
    mag = {1'b0, qb[W]};
    if (!pos_s[W]) begin
      quo = '0;
    end else if (ovf_s[W]) begin
      quo = neg_s[W] ? W'(SAT_MIN) : W'(SAT_MAX);
    end else if (neg_s[W]) begin
      quo = (mag > (W+1)'(2 ** (W - 1))) ? W'(SAT_MIN) : W'(-mag);
    end else begin
      quo = (mag > (W+1)'(SAT_MAX)) ? W'(SAT_MAX) : mag[W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/bgk_lane.sv]
// One direction lane: equilibrium polynomial, weighted scale by 1/(36*ONE), BGK relaxation.
// Depends on bgk_pkg.
`default_nettype none

module bgk_lane (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [bgk_pkg::DIR_W-1:0]    dir,
  input  wire bgk_pkg::lane_in_t            lin,
  input  wire logic [bgk_pkg::RATE_W-1:0]   omega,
  input  wire bgk_pkg::word_t               f,
  input  wire logic                         inlet,
  output bgk_pkg::word_t                    post
);
  import bgk_pkg::*;

  localparam logic signed [POLY_W-1:0] ONE_P = POLY_W'(ONE);
  localparam logic [RCP_W-1:0]         RCP   = RCP_W'(RECIP);

  logic signed [CU_W-1:0]        cu1, cu2;
  logic [SQ_W-1:0]               sq2;
  logic signed [POLY_W-1:0]      poly3;
  logic signed [W+POLY_W-1:0]    prod4;
  logic [T_W-1:0]                t5;
  logic [P9_W-1:0]               p6;
  word_t                         cur7, cur8;
  logic signed [W:0]             diff7;
  logic signed [M_W-1:0]         m8;
  logic                          neg5, neg6;
  word_t                         rho1, rho2, rho3;
  logic [USQ_W-1:0]              usq1, usq2;
  word_t                         f1, f2, f3, f4, f5, f6;
  logic                          in1, in2, in3, in4, in5, in6;

  logic signed [CU_W-1:0]        tx, ty;
  logic signed [2*CU_W-1:0]      sqf;
  logic signed [POLY_W-1:0]      c1, c3;
  logic [SQ_W+3:0]               s9;
  logic signed [PROD_W-1:0]      xs;
  logic [PROD_W-1:0]             xmag, xsh;
  logic [W:0]                    qv;
  word_t                         feq, cur;
  logic signed [M_W-1:0]         madj, mr, dd;

  always_comb begin
    case (dir_x(dir))
      2'sd1:   tx = CU_W'(lin.ux);
      -2'sd1:  tx = -CU_W'(lin.ux);
      default: tx = '0;
    endcase
    case (dir_y(dir))
      2'sd1:   ty = CU_W'(lin.uy);
      -2'sd1:  ty = -CU_W'(lin.uy);
      default: ty = '0;
    endcase
    sqf  = cu1 * cu1;
    c1   = POLY_W'(cu2);
    c3   = c1 + (c1 <<< 1);
    s9   = (SQ_W+4)'(sq2) + ((SQ_W+4)'(sq2) << 3);
    xs   = PROD_W'(prod4) <<< weight_shift(dir);
    xmag = xs[PROD_W-1] ? PROD_W'(-xs) : PROD_W'(xs);
    xsh  = xmag >> (FRAC_BITS + 2);
    qv   = (W+1)'(p6 >> RECIP_K);
    if (neg6) feq = (qv > (W+1)'(2 ** (W - 1))) ? W'(SAT_MIN) : W'(-qv);
    else      feq = (qv > (W+1)'(SAT_MAX)) ? W'(SAT_MAX) : qv[W-1:0];
    cur  = in6 ? feq : f6;
    madj = m8 + (m8[M_W-1] ? M_W'(ONE - 1) : '0);
    mr   = madj >>> FRAC_BITS;
    dd   = M_W'(cur8) - mr;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cu1   <= tx + ty;
      rho1  <= lin.rho;
      usq1  <= lin.usq3;
      f1    <= f;
      in1   <= inlet;

      sq2   <= sqf[SQ_W-1:0];
      cu2   <= cu1;
      rho2  <= rho1;
      usq2  <= usq1;
      f2    <= f1;
      in2   <= in1;

      poly3 <= ONE_P + c3 + POLY_W'(s9 >> (FRAC_BITS + 1)) - POLY_W'(usq2);
      rho3  <= rho2;
      f3    <= f2;
      in3   <= in2;

      prod4 <= rho3 * poly3;
      f4    <= f3;
      in4   <= in3;

      t5    <= (xsh >= PROD_W'(T_MAX)) ? T_W'(T_MAX) : xsh[T_W-1:0];
      neg5  <= xs[PROD_W-1];
      f5    <= f4;
      in5   <= in4;

      p6    <= P9_W'(t5) * P9_W'(RCP);
      neg6  <= neg5;
      f6    <= f5;
      in6   <= in5;

      cur7  <= cur;
      diff7 <= (W+1)'(cur) - (W+1)'(feq);

      m8    <= $signed({1'b0, omega}) * diff7;
      cur8  <= cur7;

      post  <= sat_word(SAT_IN_W'(dd));
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// Testbench for d2q9_bgk_cell_collision: drives random and directed lattice cells
// with bursty input and stalling output, predicts each collision result in-house.
// Depends on bgk_pkg and the d2q9_bgk_cell_collision RTL.
`default_nettype none

class collision_scoreboard;
  bgk_pkg::out_word_t pending_cells[$];
  int unsigned mismatches;
  int unsigned matched;
  longint rate;
  longint inlet_ux;

  function new();
    mismatches = 0;
    matched = 0;
  endfunction

  static function longint clamp(longint v);
    if (v > bgk_pkg::SAT_MAX) return bgk_pkg::SAT_MAX;
    if (v < bgk_pkg::SAT_MIN) return bgk_pkg::SAT_MIN;
    return v;
  endfunction

  static function longint shr_floor(longint v, int sh);
    longint d;
    d = longint'(1) << sh;
    if (v >= 0) return v / d;
    return -((-v + d - 1) / d);
  endfunction

  function bgk_pkg::out_word_t collide(bgk_pkg::in_word_t c);
    longint cx[9] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
    longint cy[9] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
    longint wn[9] = '{16, 4, 4, 4, 4, 1, 1, 1, 1};
    int opp[9] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
    longint one, f[9], post[9], sum, mx, my, rho, ux, uy, usq3, cu, poly, feq, cur;
    bgk_pkg::word_t w[9];
    bgk_pkg::out_word_t r;
    one = longint'(1) << bgk_pkg::FRAC_BITS;
    w = '{c.in_rest, c.in_east, c.in_north, c.in_west, c.in_south,
          c.in_northeast, c.in_northwest, c.in_southwest, c.in_southeast};
    sum = 0; mx = 0; my = 0;
    for (int q = 0; q < 9; q++) begin
      f[q] = longint'(w[q]);
      sum += f[q];
      mx += cx[q] * f[q];
      my += cy[q] * f[q];
    end
    rho = clamp(sum);
    if (rho > 0) begin
      ux = clamp((mx * one) / rho);
      uy = clamp((my * one) / rho);
    end else begin
      ux = 0;
      uy = 0;
    end
    if (c.is_inlet) begin
      rho = clamp(one);
      ux = inlet_ux;
      uy = 0;
    end
    usq3 = shr_floor(3 * (ux * ux + uy * uy), bgk_pkg::FRAC_BITS + 1);
    for (int q = 0; q < 9; q++) begin
      cu = cx[q] * ux + cy[q] * uy;
      poly = one + 3 * cu + shr_floor(9 * cu * cu, bgk_pkg::FRAC_BITS + 1) - usq3;
      feq = clamp((wn[q] * rho * poly) / (36 * one));
      cur = c.is_inlet ? feq : f[q];
      post[q] = clamp(cur - (rate * (cur - feq)) / one);
    end
    for (int q = 0; q < 9; q++) begin
      w[q] = bgk_pkg::word_t'(c.is_obstacle ? post[opp[q]] : post[q]);
    end
    r = '{w[0], w[1], w[2], w[3], w[4], w[5], w[6], w[7], w[8],
          bgk_pkg::word_t'(rho), bgk_pkg::word_t'(ux), bgk_pkg::word_t'(uy)};
    return r;
  endfunction

  function void note_cell(bgk_pkg::in_word_t c);
    pending_cells.push_back(collide(c));
  endfunction

  function void check_result(bgk_pkg::out_word_t got);
    bgk_pkg::out_word_t exp_w;
    if (pending_cells.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_w = pending_cells.pop_front();
    if (got !== exp_w) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %h actual %h", exp_w, got);
    end else begin
      matched++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bgk_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  reg_index_t cfg_index = REG_RELAX_RATE;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_word;

  collision_scoreboard board = new();
  int idle_cycles = 0;
  int unsigned inlet_cells = 0, wall_cells = 0;
  bit long_hold = 0;
  bit hold_done = 0;

  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG = 20000;

  d2q9_bgk_cell_collision uut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_result(out_word);
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("[d2q9_bgk_cell_collision] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 0;
    else if (long_hold) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 9) < 3);
  end

  initial begin
    @(posedge clk);
    wait (!rst);
    repeat (600) @(posedge clk);
    long_hold = 1;
    repeat (150) @(posedge clk);
    long_hold = 0;
    hold_done = 1;
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    if (idx == REG_RELAX_RATE) board.rate = longint'(val[RATE_W-1:0]);
    else board.inlet_ux = longint'(signed'(val[W-1:0]));
  endtask

  function automatic word_t rand_dist(int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($urandom_range(0, 2 * ONE) - ONE / 4);
      default: return word_t'($urandom_range(0, ONE / 3));
    endcase
  endfunction

  task automatic send_cell(in_word_t c);
    in_valid <= 1;
    in_word <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_cell(c);
    if (c.is_inlet) inlet_cells++;
    if (c.is_obstacle) wall_cells++;
  endtask

  task automatic send_random(int count);
    in_word_t c;
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9) < 2 ? 0 : ($urandom_range(0, 1) ? 1 : 2);
      c.in_rest = rand_dist(mode);
      c.in_east = rand_dist(mode);
      c.in_north = rand_dist(mode);
      c.in_west = rand_dist(mode);
      c.in_south = rand_dist(mode);
      c.in_northeast = rand_dist(mode);
      c.in_northwest = rand_dist(mode);
      c.in_southwest = rand_dist(mode);
      c.in_southeast = rand_dist(mode);
      c.is_obstacle = ($urandom_range(0, 3) == 0);
      c.is_inlet = ($urandom_range(0, 4) == 0);
      send_cell(c);
      if ($urandom_range(0, 5) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (board.pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_word_t c;
    word_t ext[4] = '{word_t'(SAT_MAX), word_t'(SAT_MIN), word_t'(0), word_t'(-1)};
    board.rate = 126031;
    board.inlet_ux = 2621;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(REG_RELAX_RATE, CFG_W'(126031));
    write_reg(REG_INLET_VELOCITY, CFG_W'(2621));

    for (int i = 0; i < 4; i++) begin
      c = '{ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i], ext[i],
            1'b0, 1'b0};
      send_cell(c);
      c.is_obstacle = 1;
      send_cell(c);
    end
    c = '{word_t'(ONE * 4 / 9), word_t'(ONE / 9), word_t'(ONE / 9), word_t'(ONE / 9),
          word_t'(ONE / 9), word_t'(ONE / 36), word_t'(ONE / 36), word_t'(ONE / 36),
          word_t'(ONE / 36), 1'b0, 1'b0};
    send_cell(c);
    c.is_inlet = 1;
    send_cell(c);
    c.is_obstacle = 1;
    send_cell(c);
    c.in_east = word_t'(SAT_MAX);
    c.is_inlet = 0;
    send_cell(c);
    c.in_west = word_t'(SAT_MIN);
    send_cell(c);
    c.in_rest = word_t'(-ONE);
    c.in_east = word_t'(ONE / 2);
    send_cell(c);
    in_valid <= 0;
    @(posedge clk);
    drain();

    send_random(600);
    drain();
    write_reg(REG_RELAX_RATE, CFG_W'(0));
    write_reg(REG_INLET_VELOCITY, CFG_W'(SAT_MIN));
    send_random(220);
    drain();
    write_reg(REG_RELAX_RATE, CFG_W'(131072));
    write_reg(REG_INLET_VELOCITY, CFG_W'(SAT_MAX));
    send_random(220);
    drain();
    write_reg(REG_RELAX_RATE, CFG_W'(2 ** RATE_W - 1));
    write_reg(REG_INLET_VELOCITY, CFG_W'(-2621));
    send_random(220);
    drain();
    write_reg(REG_RELAX_RATE, CFG_W'(ONE));
    write_reg(REG_INLET_VELOCITY, CFG_W'(ONE / 10));
    send_random(280);
    drain();

    $display("covered %0d cells (%0d inlet, %0d wall) over five register settings",
             board.matched + board.mismatches, inlet_cells, wall_cells);
    if (board.mismatches == 0 && board.pending_cells.size() == 0)
      $display("[d2q9_bgk_cell_collision] OK");
    else
      $display("[d2q9_bgk_cell_collision] ERROR");
    $finish;
  end
endmodule

`default_nettype wire

[sim.f]
rtl/bgk_pkg.sv
rtl/bgk_div.sv
rtl/bgk_lane.sv
rtl/d2q9_bgk_cell_collision.sv
dv/testbench.sv
